// ===== rtl/core/cnl_pkg.sv =====
// ----------------------------------------------------------------------------
// cnl_pkg
// Shared types and constants for the fixed-radius neighbor list block.
// ----------------------------------------------------------------------------
package cnl_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int DIMS_DEFAULT       = 3;
   localparam int COORD_BITS_DEFAULT = 20;

   localparam int INDEX_BITS        = 6;
   localparam int COORD_FIELD_BITS  = 20;
   localparam int CUTOFF_BITS       = 44;
   localparam int COUNT_BITS        = 7;
   localparam int INDEX_LIMIT       = 64;

   localparam logic [COUNT_BITS-1:0]  POINT_COUNT_RESET = 7'd64;
   localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET      = '0;

   typedef enum logic [0:0] {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_CUTOFF_SQUARED = 1'b0,
      CSR_POINT_COUNT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                                req_type;
      logic [INDEX_BITS-1:0]               point_index;
      logic signed [COORD_FIELD_BITS-1:0]  coord_x;
      logic signed [COORD_FIELD_BITS-1:0]  coord_y;
      logic signed [COORD_FIELD_BITS-1:0]  coord_z;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] neighbour_index;
      logic                  found;
      logic                  last;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type          index;
      logic [CUTOFF_BITS-1:0] value;
   } csr_payload_type;

   // sequencer -> distance unit
   typedef struct packed {
      logic step;
      logic first;
      logic last;
   } dist_ctrl_type;

   // distance unit -> sequencer
   typedef struct packed {
      logic done;
      logic near;
   } dist_status_type;

endpackage

// ===== rtl/core/cnl_stream_if.sv =====
// ----------------------------------------------------------------------------
// cnl_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface cnl_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cutoff_neighbour_list.sv =====
// ----------------------------------------------------------------------------
// cutoff_neighbour_list
// Brute-force fixed-radius neighbor list over a small point store.
// ----------------------------------------------------------------------------
// A load beat writes one point slot. A query beat reads the named point, then
// walks slots 0 .. min(point_count, MAX_POINTS, 64)-1 through a single
// squared-distance unit that handles one coordinate per cycle, and skips the
// queried point itself. The walk waits while the result channel stalls. Input
// ready is low for the whole query. Neighbors come out in ascending index
// order; the final beat has last set, and a query with no neighbors returns a
// single beat with found clear. One result is buffered, so the next request
// can be taken while the final result still waits.
// ----------------------------------------------------------------------------
module cutoff_neighbour_list #(
   parameter int MAX_POINTS = cnl_pkg::MAX_POINTS_DEFAULT,
   parameter int DIMS       = cnl_pkg::DIMS_DEFAULT,
   parameter int COORD_BITS = cnl_pkg::COORD_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   cnl_stream_if.sink    req_bus,
   cnl_stream_if.source  rsp_bus,
   cnl_stream_if.sink    csr_bus
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int PW    = DIMS * COORD_BITS;
   localparam int DCW   = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int IW    = cnl_pkg::INDEX_BITS;
   localparam int NW    = cnl_pkg::COUNT_BITS;
   localparam int FW    = cnl_pkg::COORD_FIELD_BITS;
   localparam int CAP   = (MAX_POINTS < cnl_pkg::INDEX_LIMIT) ?
                          MAX_POINTS : cnl_pkg::INDEX_LIMIT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QREAD,
      ST_QCAP,
      ST_READ,
      ST_CALC,
      ST_SETTLE,
      ST_EMIT,
      ST_FINISH
   } state_type;

   typedef logic [DIMS-1:0][COORD_BITS-1:0] point_type;

   state_type                       state_ff;
   logic [cnl_pkg::CUTOFF_BITS-1:0] cutoff_ff;
   logic [NW-1:0]                   count_ff;
   logic [NW-1:0]                   limit_ff;
   logic [NW-1:0]                   j_ff;
   logic [NW-1:0]                   j_next;
   logic [DCW-1:0]                  d_ff;
   logic [IW-1:0]                   qidx_ff;
   point_type                       q_ff;
   logic                            hit_ff;
   logic                            held_valid_ff;
   logic [IW-1:0]                   held_idx_ff;
   logic                            rsp_valid_ff;
   cnl_pkg::rsp_payload_type        rsp_data_ff;

   cnl_pkg::req_payload_type        req;
   point_type                       load_point;
   point_type                       rd_point;
   logic [PW-1:0]                   rd_data;
   logic                            req_fire;
   logic                            idx_in_range;
   logic [NW-1:0]                   limit_in;
   logic                            out_free;
   logic                            rsp_load;
   logic                            last_dim;
   logic                            at_end;
   logic [AW-1:0]                   rd_addr;
   logic                            wr_en;
   cnl_pkg::dist_ctrl_type          dctrl;
   cnl_pkg::dist_status_type        dstat;

   assign req      = req_bus.data;
   assign req_fire = req_bus.valid & req_bus.ready;
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign last_dim = (d_ff == DCW'(DIMS - 1));
   assign j_next   = j_ff + NW'(1);
   assign at_end   = (j_next >= limit_ff);

   // a result beat is loaded when a held hit is pushed out or the query ends
   assign rsp_load = ((state_ff == ST_EMIT) & hit_ff & held_valid_ff & out_free) |
                     ((state_ff == ST_FINISH) & out_free);

   assign idx_in_range = (32'(req.point_index) < 32'(MAX_POINTS));
   assign limit_in     = (count_ff > NW'(CAP)) ? NW'(CAP) : count_ff;

   // low COORD_BITS of each sign-extended field, read back as signed by the
   // distance unit
   always_comb begin
      logic [FW+COORD_BITS-1:0] ext;
      for (int d = 0; d < DIMS; d++) begin
         unique case (d)
            0:       ext = {{COORD_BITS{req.coord_x[FW-1]}}, req.coord_x};
            1:       ext = {{COORD_BITS{req.coord_y[FW-1]}}, req.coord_y};
            default: ext = {{COORD_BITS{req.coord_z[FW-1]}}, req.coord_z};
         endcase
         load_point[d] = ext[COORD_BITS-1:0];
      end
   end

   assign wr_en    = req_fire & (req.req_type == cnl_pkg::REQ_LOAD) & idx_in_range;
   assign rd_addr  = (state_ff == ST_QREAD) ? AW'(qidx_ff) : AW'(j_ff);
   assign rd_point = rd_data;

   cnl_store #(
      .DEPTH (MAX_POINTS),
      .WIDTH (PW),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req.point_index)),
      .wr_data (load_point),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign dctrl.step  = (state_ff == ST_CALC);
   assign dctrl.first = (d_ff == '0);
   assign dctrl.last  = last_dim;

   cnl_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (dctrl),
      .coord_a (q_ff[d_ff]),
      .coord_b (rd_point[d_ff]),
      .cutoff  (cutoff_ff),
      .status  (dstat)
   );

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= cnl_pkg::CUTOFF_RESET;
         count_ff  <= cnl_pkg::POINT_COUNT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.data.index)
            cnl_pkg::CSR_CUTOFF_SQUARED: cutoff_ff <= csr_bus.data.value;
            cnl_pkg::CSR_POINT_COUNT:    count_ff  <= csr_bus.data.value[NW-1:0];
            default:                     cutoff_ff <= cutoff_ff;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req.req_type == cnl_pkg::REQ_QUERY) begin
                  qidx_ff       <= req.point_index;
                  limit_ff      <= limit_in;
                  held_valid_ff <= 1'b0;
                  if (idx_in_range && limit_in != '0) begin
                     state_ff <= ST_QREAD;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_QREAD: begin
               state_ff <= ST_QCAP;
            end
            ST_QCAP: begin
               q_ff     <= rd_point;
               j_ff     <= '0;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               d_ff <= '0;
               if (j_ff == NW'(qidx_ff)) begin
                  if (at_end) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     j_ff <= j_next;
                  end
               end else begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (last_dim) begin
                  state_ff <= ST_SETTLE;
               end else begin
                  d_ff <= d_ff + DCW'(1);
               end
            end
            ST_SETTLE: begin
               if (dstat.done) begin
                  hit_ff   <= dstat.near;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // a new hit pushes the held one out as a non-final beat
               if (!hit_ff || !held_valid_ff || out_free) begin
                  if (hit_ff) begin
                     if (held_valid_ff) begin
                        rsp_data_ff.neighbour_index <= held_idx_ff;
                        rsp_data_ff.found           <= 1'b1;
                        rsp_data_ff.last            <= 1'b0;
                     end
                     held_valid_ff <= 1'b1;
                     held_idx_ff   <= j_ff[IW-1:0];
                  end
                  if (at_end) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     j_ff     <= j_next;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff.neighbour_index <= held_valid_ff ? held_idx_ff : '0;
                  rsp_data_ff.found           <= held_valid_ff;
                  rsp_data_ff.last            <= 1'b1;
                  state_ff                    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

endmodule

// ===== rtl/core/cnl_store.sv =====
// ----------------------------------------------------------------------------
// cnl_store
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cnl_store #(
   parameter int DEPTH = cnl_pkg::MAX_POINTS_DEFAULT,
   parameter int WIDTH = cnl_pkg::DIMS_DEFAULT * cnl_pkg::COORD_BITS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cnl_dist.sv =====
// ----------------------------------------------------------------------------
// cnl_dist
// Shared squared-distance unit: one coordinate per step through a single
// multiplier, accumulated and compared against the cutoff.
// ----------------------------------------------------------------------------
module cnl_dist #(
   parameter int COORD_BITS = cnl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cnl_pkg::dist_ctrl_type            ctrl,
   input  logic [COORD_BITS-1:0]             coord_a,
   input  logic [COORD_BITS-1:0]             coord_b,
   input  logic [cnl_pkg::CUTOFF_BITS-1:0]   cutoff,
   output cnl_pkg::dist_status_type          status
);

   localparam int CW = cnl_pkg::CUTOFF_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int AW = CW + 2;
   localparam int XW = (PW > AW) ? PW : AW;

   logic signed [DW-1:0] diff;
   logic [DW-1:0]        mag;
   logic [PW-1:0]        prod_in, prod_ff;
   logic                 val_ff, first_ff, last_ff;
   logic [XW-1:0]        prod_wide;
   logic                 term_big;
   logic [AW-1:0]        acc_in, acc_ff;
   logic                 big_in, big_ff;
   logic                 done_ff;

   always_comb begin
      diff    = DW'($signed(coord_a)) - DW'($signed(coord_b));
      mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
      prod_in = PW'(mag) * PW'(mag);
   end

   // anything at or above 2^44 can never pass the compare
   always_comb begin
      prod_wide = XW'(prod_ff);
      term_big  = |prod_wide[XW-1:CW];
      acc_in    = (first_ff ? '0 : acc_ff) + AW'(prod_wide[CW-1:0]);
      big_in    = term_big | (first_ff ? 1'b0 : big_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         val_ff  <= ctrl.step;
         done_ff <= val_ff & last_ff;
      end
      first_ff <= ctrl.first;
      last_ff  <= ctrl.last;
      prod_ff  <= prod_in;
      if (val_ff) begin
         acc_ff <= acc_in;
         big_ff <= big_in;
      end
   end

   assign status.done = done_ff;
   assign status.near = ~big_ff & (acc_ff < AW'(cutoff));

endmodule

// ===== rtl/core/cnl_checker.sv =====
// ----------------------------------------------------------------------------
// cnl_checker
// Port-level checks for the neighbor list block, bound to the top level.
// ----------------------------------------------------------------------------
module cnl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_type,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cnl_pkg::INDEX_BITS-1:0] rsp_index,
   input logic                        rsp_found,
   input logic                        rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) &&
         $stable(rsp_found) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // mid-query beat means the block is still busy
   a_busy_mid_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken while query results still pending");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == cnl_pkg::REQ_QUERY |=> !req_ready)
      else $error("ready right after a query beat");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_index == '0)
      else $error("empty result not final or index nonzero");

endmodule

bind cutoff_neighbour_list cnl_checker u_cnl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_type  (req_bus.data.req_type),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_index (rsp_bus.data.neighbour_index),
   .rsp_found (rsp_bus.data.found),
   .rsp_last  (rsp_bus.data.last)
);
